### rtl/lap3_pkg.sv
// Shared types and constants for the 3x3 Laplacian stencil.
package lap3_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_PIXEL_BITS  = 16;

  localparam int CFG_WIDTH_BITS  = 11;
  localparam int CFG_HEIGHT_BITS = 16;
  localparam int APB_ADDR_BITS   = 4;
  localparam int APB_DATA_BITS   = 32;

  localparam logic [CFG_WIDTH_BITS-1:0]  RST_FRAME_WIDTH  = 11'd512;
  localparam logic [CFG_HEIGHT_BITS-1:0] RST_FRAME_HEIGHT = 16'd512;
  localparam logic                       RST_STENCIL_MODE = 1'b0;

  localparam int LAP_BITS = 20;
  localparam int LAP_MAX  = 524287;
  localparam int LAP_MIN  = -524288;

  // result buffer depth, also the credit limit on the input side
  localparam int OFIFO_DEPTH = 8;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_STENCIL_MODE = 2'd2
  } reg_idx_t;

  typedef enum logic {
    MODE_FOUR  = 1'b0,
    MODE_EIGHT = 1'b1
  } stencil_mode_t;

  typedef struct packed {
    logic emit;   // item releases a result
    logic inner;  // result position is off the frame border
    logic last;   // result is the final one of the frame
  } item_tag_t;

  typedef struct packed {
    logic signed [LAP_BITS-1:0] lap_value;
    logic                       frame_last;
  } result_t;

endpackage

### rtl/lap3_ifs.sv
// Valid/ready stream interfaces for pixels in and Laplacian results out.
interface lap3_pix_if #(
  parameter int PIXEL_BITS = lap3_pkg::DEF_PIXEL_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] pixel;
  logic                         is_flush;

  modport source (output valid, output pixel, output is_flush, input ready);
  modport sink   (input valid, input pixel, input is_flush, output ready);
endinterface

interface lap3_res_if;
  import lap3_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [LAP_BITS-1:0] lap_value;
  logic                       frame_last;

  modport source (output valid, output lap_value, output frame_last, input ready);
  modport sink   (input valid, input lap_value, input frame_last, output ready);
endinterface

### rtl/lap3_linebuf.sv
// Line store memory: upper and middle row samples packed per column.
module lap3_linebuf #(
  parameter int MAX_WIDTH  = lap3_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = lap3_pkg::DEF_PIXEL_BITS,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int DW = 2 * PIXEL_BITS
) (
  input  logic          clk,
  input  logic [CW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [CW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);
  logic [DW-1:0] mem [MAX_WIDTH];

  // read returns old data on a same-address write; caller forwards
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

### rtl/lap3_ctrl.sv
// Input and output position counters, column select and per-item tags.
module lap3_ctrl #(
  parameter int MAX_WIDTH = lap3_pkg::DEF_MAX_WIDTH,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     accept,
  input  logic [lap3_pkg::CFG_WIDTH_BITS-1:0]      frame_width,
  input  logic [lap3_pkg::CFG_HEIGHT_BITS-1:0]     frame_height,
  output logic [CW-1:0]                            col,
  output lap3_pkg::item_tag_t                      tag
);
  import lap3_pkg::*;

  localparam int WW = (CW + 1 > CFG_WIDTH_BITS) ? CW + 1 : CFG_WIDTH_BITS;
  localparam int HW = CFG_HEIGHT_BITS + 1;

  logic [CW-1:0]              in_col;
  logic [CFG_HEIGHT_BITS-1:0] in_row;
  logic [CW-1:0]              out_col;
  logic [CFG_HEIGHT_BITS-1:0] out_row;

  logic [WW-1:0]              fw;
  logic [WW-1:0]              w_eff;
  logic [CFG_HEIGHT_BITS-1:0] h_eff;
  logic                       in_wrap;
  logic                       out_col_end;
  logic                       out_row_end;

  always_comb begin
    fw = WW'(frame_width);
    if (fw < WW'(3)) begin
      w_eff = WW'(3);
    end else if (fw > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = fw;
    end
    h_eff = (frame_height < CFG_HEIGHT_BITS'(3)) ? CFG_HEIGHT_BITS'(3) : frame_height;

    // column clamps if the width shrank under a running counter
    col = (WW'(in_col) < w_eff) ? in_col : CW'(w_eff - WW'(1));
    in_wrap     = (WW'(col) + WW'(1)) >= w_eff;
    out_col_end = (WW'(out_col) + WW'(1)) >= w_eff;
    out_row_end = (HW'(out_row) + HW'(1)) >= HW'(h_eff);

    tag.emit  = (in_row >= CFG_HEIGHT_BITS'(2)) ||
                ((in_row == CFG_HEIGHT_BITS'(1)) && (in_col != '0));
    tag.inner = (out_row != '0) && !out_row_end && (out_col != '0) && !out_col_end;
    tag.last  = out_row_end && out_col_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (accept) begin
      if (tag.emit && tag.last) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (in_wrap) begin
          in_col <= '0;
          if (in_row != '1) begin
            in_row <= in_row + CFG_HEIGHT_BITS'(1);
          end
        end else begin
          in_col <= col + CW'(1);
        end
        if (tag.emit) begin
          if (out_col_end) begin
            out_col <= '0;
            out_row <= out_row + CFG_HEIGHT_BITS'(1);
          end else begin
            out_col <= out_col + CW'(1);
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && tag.emit && tag.last) |=>
      (in_col == '0 && in_row == '0 && out_col == '0 && out_row == '0))
    else $error("counters not cleared after frame end");

  a_no_emit_holds_out: assert property (@(posedge clk) disable iff (rst)
    (accept && !tag.emit) |=> (out_col == $past(out_col) && out_row == $past(out_row)))
    else $error("output position moved without a result");
`endif

endmodule

### rtl/lap3_window.sv
// Line store read-modify-write, 3x3 window and the two-stage stencil datapath.
module lap3_window #(
  parameter int MAX_WIDTH  = lap3_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = lap3_pkg::DEF_PIXEL_BITS,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int DW = 2 * PIXEL_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [CW-1:0]                col,
  input  logic signed [PIXEL_BITS-1:0] pix,
  input  lap3_pkg::item_tag_t          tag,
  input  logic                         stencil_mode,
  input  logic [DW-1:0]                rd_data,
  output logic                         wr_en,
  output logic [CW-1:0]                wr_addr,
  output logic [DW-1:0]                wr_data,
  output logic                         push,
  output lap3_pkg::result_t            push_data
);
  import lap3_pkg::*;

  localparam int SUMW = PIXEL_BITS + 2;
  localparam int LW   = PIXEL_BITS + 5;
  localparam int SW   = (LW > LAP_BITS) ? LW : LAP_BITS + 1;

  // stage 1: line store data back
  logic                         s1_valid;
  logic [CW-1:0]                s1_col;
  logic signed [PIXEL_BITS-1:0] s1_pix;
  item_tag_t                    s1_tag;
  logic                         s1_fwd;
  logic [DW-1:0]                fwd_data;
  logic [DW-1:0]                rd_eff;
  logic signed [PIXEL_BITS-1:0] up;
  logic signed [PIXEL_BITS-1:0] mid;

  logic signed [PIXEL_BITS-1:0] win [3][3];

  // stage 2: window holds this item's neighborhood
  logic                         s2_valid;
  item_tag_t                    s2_tag;
  logic signed [SUMW-1:0]       edge_sum;
  logic signed [SUMW-1:0]       corner_sum;

  // stage 3: final combine
  logic                         s3_valid;
  item_tag_t                    s3_tag;
  logic signed [SUMW-1:0]       s3_edges;
  logic signed [SUMW-1:0]       s3_corners;
  logic signed [PIXEL_BITS-1:0] s3_center;
  logic signed [LW-1:0]         center_x;
  logic signed [LW-1:0]         lap_full;
  logic signed [SW-1:0]         lap_x;
  logic signed [LAP_BITS-1:0]   lap_sat;

  // previous item writes the same column at the edge this one was read
  assign rd_eff  = s1_fwd ? fwd_data : rd_data;
  assign up      = rd_eff[DW-1:PIXEL_BITS];
  assign mid     = rd_eff[PIXEL_BITS-1:0];

  assign wr_en   = s1_valid;
  assign wr_addr = s1_col;
  assign wr_data = {mid, s1_pix};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        s1_fwd <= s1_valid && (s1_col == col);
      end
      s2_valid <= s1_valid && s1_tag.emit;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= col;
      s1_pix   <= pix;
      s1_tag   <= tag;
      fwd_data <= {mid, s1_pix};
    end
    s2_tag     <= s1_tag;
    s3_tag     <= s2_tag;
    s3_edges   <= edge_sum;
    s3_corners <= corner_sum;
    s3_center  <= win[1][1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= up;
      win[1][2] <= mid;
      win[2][2] <= s1_pix;
    end
  end

  always_comb begin
    edge_sum   = SUMW'(win[0][1]) + SUMW'(win[2][1]) + SUMW'(win[1][0]) + SUMW'(win[1][2]);
    corner_sum = SUMW'(win[0][0]) + SUMW'(win[0][2]) + SUMW'(win[2][0]) + SUMW'(win[2][2]);
  end

  always_comb begin
    center_x = LW'(s3_center);
    if (stencil_mode == MODE_EIGHT) begin
      lap_full = (center_x <<< 3) - LW'(s3_edges) - LW'(s3_corners);
    end else begin
      lap_full = (center_x <<< 2) - LW'(s3_edges);
    end
    lap_x = SW'(lap_full);
    if (lap_x > SW'(LAP_MAX)) begin
      lap_sat = LAP_BITS'(LAP_MAX);
    end else if (lap_x < SW'(LAP_MIN)) begin
      lap_sat = LAP_BITS'(LAP_MIN);
    end else begin
      lap_sat = lap_x[LAP_BITS-1:0];
    end
    push                 = s3_valid;
    push_data.lap_value  = s3_tag.inner ? lap_sat : '0;
    push_data.frame_last = s3_tag.last;
  end

`ifndef SYNTHESIS
  a_fwd_only_after_item: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_fwd) |-> $past(s1_valid))
    else $error("forwarding without a preceding item");
`endif

endmodule

### rtl/lap3_ofifo.sv
// Result buffer between the datapath and the output channel.
module lap3_ofifo #(
  parameter int DEPTH = lap3_pkg::OFIFO_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lap3_pkg::result_t push_data,
  input  logic              pop,
  output logic              head_valid,
  output lap3_pkg::result_t head_data
);
  import lap3_pkg::*;

  result_t       entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < (AW+1)'(DEPTH)))
    else $error("result buffer overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("result buffer underflow");
`endif

endmodule

### rtl/laplacian_3x3_stencil.sv
// Top level of the streaming 3x3 Laplacian: config registers, credit and wiring.
//
//   channel   dir  payload                          transaction
//   pixels    in   pixel[PIXEL_BITS], is_flush      valid & ready
//   results   out  lap_value[20], frame_last        valid & ready
//   apb       in   frame_width, frame_height, mode  psel & penable & pwrite
//
// One pixel per clock while results drain; the line store does one read and at most one write per cycle.
// A result is offered once the item releasing it (one row plus one pixel later) has passed
// the stage 1, window, stage 3 and result buffer registers.
// Up to 8 results may wait; pixels.ready drops while 8 are outstanding.
// Reset clears counters and window; the line store is not cleared and needs no pass.
module laplacian_3x3_stencil #(
  parameter int MAX_WIDTH  = lap3_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = lap3_pkg::DEF_PIXEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  lap3_pix_if.sink                            pixels,
  lap3_res_if.source                          results,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lap3_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [lap3_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [lap3_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready
);
  import lap3_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int DW  = 2 * PIXEL_BITS;
  localparam int OCW = $clog2(OFIFO_DEPTH + 1);

  logic [CFG_WIDTH_BITS-1:0]  frame_width;
  logic [CFG_HEIGHT_BITS-1:0] frame_height;
  logic                       stencil_mode;
  reg_idx_t                   reg_idx;

  logic                         in_accept;
  logic                         out_accept;
  logic [OCW-1:0]               outstanding;
  logic signed [PIXEL_BITS-1:0] pix_v;
  logic [CW-1:0]                col;
  item_tag_t                    tag;
  logic [DW-1:0]                rd_data;
  logic                         wr_en;
  logic [CW-1:0]                wr_addr;
  logic [DW-1:0]                wr_data;
  logic                         push;
  result_t                      push_data;
  logic                         head_valid;
  result_t                      head_data;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      stencil_mode <= RST_STENCIL_MODE;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[CFG_WIDTH_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[CFG_HEIGHT_BITS-1:0];
        REG_STENCIL_MODE: stencil_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DATA_BITS'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_BITS'(frame_height);
      REG_STENCIL_MODE: prdata = APB_DATA_BITS'(stencil_mode);
      default:          prdata = '0;
    endcase
  end

  // credit: results accepted in but not yet taken, bounded by the buffer depth
  assign pixels.ready = (outstanding < OCW'(OFIFO_DEPTH));
  assign in_accept    = pixels.valid && pixels.ready;
  assign out_accept   = results.valid && results.ready;
  assign pix_v        = pixels.is_flush ? '0 : pixels.pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + OCW'(in_accept && tag.emit) - OCW'(out_accept);
    end
  end

  lap3_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .col          (col),
    .tag          (tag)
  );

  lap3_linebuf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_linebuf (
    .clk     (clk),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lap3_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .col          (col),
    .pix          (pix_v),
    .tag          (tag),
    .stencil_mode (stencil_mode),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .push         (push),
    .push_data    (push_data)
  );

  lap3_ofifo #(
    .DEPTH (OFIFO_DEPTH)
  ) u_ofifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (out_accept),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign results.valid      = head_valid;
  assign results.lap_value  = head_data.lap_value;
  assign results.frame_last = head_data.frame_last;

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding <= OCW'(OFIFO_DEPTH))
    else $error("outstanding results exceed buffer depth");

  a_valid_has_credit: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (outstanding != '0))
    else $error("result offered with no outstanding transaction");
`endif

endmodule
